// File: rtl/lped_pkg.sv
// Shared types and constants for the length-prefixed event deframer.
`timescale 1ns / 1ps
package lped_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] MODE_BYTES32 = 2'd0;
  localparam logic [1:0] MODE_WORDS32 = 2'd1;
  localparam logic [1:0] MODE_EXCL16  = 2'd2;
  localparam logic [1:0] MODE_INCL16  = 2'd3;

  localparam logic [1:0] SIZE_MODE_RESET = MODE_INCL16;

  localparam logic REG_SIZE_MODE = 1'b0;
  localparam logic REG_HIGH_HALF = 1'b1;

  localparam logic [2:0] ST_DATA  = 3'd0;
  localparam logic [2:0] ST_SIZE  = 3'd1;
  localparam logic [2:0] ST_TRUNC = 3'd2;
  localparam logic [2:0] ST_ODD   = 3'd3;
  localparam logic [2:0] ST_SPLIT = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HEAD  = 2'd1,
    PH_HEAD2 = 2'd2,
    PH_BODY  = 2'd3
  } parse_phase_t;

  typedef struct packed {
    logic [15:0] data_word;
    logic        buffer_end;
    logic [15:0] event_limit;
  } item_t;

  typedef struct packed {
    logic [15:0] out_word;
    logic        event_first;
    logic        event_last;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic [15:0] data_word;
    logic        buffer_end;
    logic [15:0] event_limit;
    logic        buffer_start;
    logic [16:0] size16;
  } word_entry_t;

endpackage

// File: rtl/length_prefixed_event_deframer.sv
// Top level of the length-prefixed event deframer with its configuration registers.
`timescale 1ns / 1ps
// The deframer takes one 16-bit buffer word per cycle and gives at most one result per
// word, so sustained throughput is one word per clock while neither side stalls; the
// parser updates its size counter and event count once per word, which sets that
// figure. An accepted word passes through a queue slot into the result register, and
// the queue of QueueDepth entries lets input and output stall independently. There is
// no clearing pass after reset. Configuration writes take effect at once and are meant
// for times when no transaction is in flight.
module length_prefixed_event_deframer
  import lped_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data
);

  logic        size_mode_unused;
  logic [1:0]  size_mode;
  logic        high_half_first;
  logic        push;
  logic        queue_full;
  logic        q_nonempty;
  logic        q_pop;
  word_entry_t push_entry;
  word_entry_t head_entry;

  assign cfg_ready        = 1'b1;
  assign size_mode_unused = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_mode       <= SIZE_MODE_RESET;
      high_half_first <= size_mode_unused;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIZE_MODE: size_mode <= cfg_data;
        REG_HIGH_HALF: high_half_first <= cfg_data[0];
        default:       size_mode <= size_mode;
      endcase
    end
  end

  lped_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .size_mode  (size_mode),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  lped_fifo #(
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (q_pop),
    .nonempty   (q_nonempty),
    .head_entry (head_entry)
  );

  lped_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_nonempty      (q_nonempty),
    .q_entry         (head_entry),
    .q_pop           (q_pop),
    .size_mode       (size_mode),
    .high_half_first (high_half_first),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result)
  );

endmodule

// File: rtl/lped_front.sv
// Intake stage that marks buffer starts and precomputes the 17-bit header size.
`timescale 1ns / 1ps
module lped_front
  import lped_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  input  logic [1:0]  size_mode,
  input  logic        queue_full,
  output logic        push,
  output word_entry_t entry
);

  logic in_buffer;

  assign item_ready = !queue_full;
  assign push       = item_valid && !queue_full;

  always_comb begin
    entry.data_word    = item.data_word;
    entry.buffer_end   = item.buffer_end;
    entry.event_limit  = item.event_limit;
    entry.buffer_start = !in_buffer;
    entry.size16       = {1'b0, item.data_word} + {16'd0, (size_mode == MODE_EXCL16)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_buffer <= 1'b0;
    end else if (push) begin
      in_buffer <= !item.buffer_end;
    end
  end

endmodule

// File: rtl/lped_fifo.sv
// Small queue of classified words between the intake and the parser.
`timescale 1ns / 1ps
module lped_fifo
  import lped_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  word_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        nonempty,
  output word_entry_t head_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW+1)'(DEPTH);

  word_entry_t   slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == FULL_CNT);
  assign nonempty   = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("Queue count exceeds its depth.");
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push && !full && !pop |=> count == $past(count) + 1'b1)
    else $error("Accepted push did not raise the queue count.");

endmodule

// File: rtl/lped_back.sv
// Event parser that walks headers and bodies and drives the result register.
`timescale 1ns / 1ps
module lped_back
  import lped_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_nonempty,
  input  word_entry_t q_entry,
  output logic        q_pop,
  input  logic [1:0]  size_mode,
  input  logic        high_half_first,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);

  parse_phase_t phase;
  parse_phase_t phase_next;
  parse_phase_t cur_phase;
  logic [31:0]  words_remaining;
  logic [31:0]  words_remaining_next;
  logic [15:0]  header_first_half;
  logic [15:0]  events_left;
  logic [15:0]  cur_events;
  logic         step;

  logic         res_vld;
  result_t      res;
  logic         fail;
  logic         drop;
  logic         ev_done;
  logic         to_head2;
  logic         to_body;
  logic [31:0]  rem_new;
  logic [31:0]  size32;
  logic [31:0]  size_words;
  logic         mode32;

  assign step      = q_nonempty && (!result_valid || result_ready);
  assign q_pop     = step;
  assign cur_phase = q_entry.buffer_start ? PH_HEAD : phase;
  assign cur_events = q_entry.buffer_start ? q_entry.event_limit : events_left;
  assign mode32    = (size_mode == MODE_BYTES32) || (size_mode == MODE_WORDS32);
  assign size32    = high_half_first ? {header_first_half, q_entry.data_word}
                                     : {q_entry.data_word, header_first_half};
  assign size_words = (size_mode == MODE_BYTES32) ? {1'b0, size32[31:1]} : size32;

  always_comb begin
    res_vld  = 1'b0;
    res      = '0;
    fail     = 1'b0;
    drop     = 1'b0;
    ev_done  = 1'b0;
    to_head2 = 1'b0;
    to_body  = 1'b0;
    rem_new  = '0;
    unique case (cur_phase)
      PH_HEAD: begin
        if (cur_events == '0) begin
          drop = 1'b1;
        end else if (mode32) begin
          res_vld = 1'b1;
          if (q_entry.buffer_end) begin
            fail       = 1'b1;
            res.status = ST_SPLIT;
          end else begin
            to_head2        = 1'b1;
            res.out_word    = q_entry.data_word;
            res.event_first = 1'b1;
          end
        end else begin
          res_vld = 1'b1;
          if (q_entry.size16 == '0) begin
            fail       = 1'b1;
            res.status = ST_SIZE;
          end else if (q_entry.size16 == 17'd1) begin
            ev_done         = 1'b1;
            res.out_word    = q_entry.data_word;
            res.event_first = 1'b1;
            res.event_last  = 1'b1;
          end else if (q_entry.buffer_end) begin
            fail       = 1'b1;
            res.status = ST_TRUNC;
          end else begin
            to_body         = 1'b1;
            rem_new         = {15'd0, q_entry.size16} - 32'd1;
            res.out_word    = q_entry.data_word;
            res.event_first = 1'b1;
          end
        end
      end
      PH_HEAD2: begin
        res_vld = 1'b1;
        if ((size_mode == MODE_BYTES32) && size32[0]) begin
          fail       = 1'b1;
          res.status = ST_ODD;
        end else if (size_words < 32'd2) begin
          fail       = 1'b1;
          res.status = ST_SIZE;
        end else if (size_words == 32'd2) begin
          ev_done        = 1'b1;
          res.out_word   = q_entry.data_word;
          res.event_last = 1'b1;
        end else if (q_entry.buffer_end) begin
          fail       = 1'b1;
          res.status = ST_TRUNC;
        end else begin
          to_body      = 1'b1;
          rem_new      = size_words - 32'd2;
          res.out_word = q_entry.data_word;
        end
      end
      PH_BODY: begin
        res_vld = 1'b1;
        if (words_remaining <= 32'd1) begin
          ev_done        = 1'b1;
          res.out_word   = q_entry.data_word;
          res.event_last = 1'b1;
        end else if (q_entry.buffer_end) begin
          fail       = 1'b1;
          res.status = ST_TRUNC;
        end else begin
          res.out_word = q_entry.data_word;
        end
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  always_comb begin
    priority if (q_entry.buffer_end || fail || drop) begin
      phase_next = PH_IDLE;
    end else if (ev_done) begin
      phase_next = PH_HEAD;
    end else if (to_head2) begin
      phase_next = PH_HEAD2;
    end else if (to_body) begin
      phase_next = PH_BODY;
    end else begin
      phase_next = cur_phase;
    end
  end

  always_comb begin
    if (to_body) begin
      words_remaining_next = rem_new;
    end else if (ev_done) begin
      words_remaining_next = '0;
    end else if ((cur_phase == PH_BODY) && !fail) begin
      words_remaining_next = words_remaining - 32'd1;
    end else begin
      words_remaining_next = words_remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      words_remaining <= '0;
      events_left     <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (step) begin
        phase           <= phase_next;
        words_remaining <= words_remaining_next;
        events_left     <= ev_done ? cur_events - 16'd1 : cur_events;
        result_valid    <= res_vld;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && to_head2) begin
      header_first_half <= q_entry.data_word;
    end
    if (step) begin
      result <= res;
    end
  end

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_DATA) |->
      (result.out_word == '0) && !result.event_first && !result.event_last)
    else $error("Error result carries word data or event marks.");
  a_end_idles: assert property (@(posedge clk) disable iff (rst)
    step && q_entry.buffer_end |=> phase == PH_IDLE)
    else $error("Parser did not return to idle at the end of a buffer.");
  a_body_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> words_remaining != '0)
    else $error("Event body entered with no words remaining.");

endmodule
